>>> rtl/core/gamepad_report_mapper_assert.svh
// ----------------------------------------------------------------------------
// Gamepad report mapper assertion macros
// Property wrappers shared by the RTL; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_REPORT_MAPPER_ASSERT_SVH
`define GAMEPAD_REPORT_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst_n is low
`define GPM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define GPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GPM_ASSERT_SAME(lbl, ante, cons, msg)
`define GPM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/gpm_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad report mapper package
// Widths, button positions, hat codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package gpm_pkg;

  // Field widths
  localparam int GPM_BTN_W  = 16;
  localparam int GPM_HAT_W  = 4;
  localparam int GPM_AXIS_W = 8;
  localparam int GPM_TRIG_W = 8;
  localparam int GPM_DZ_W   = 7;

  // Axis divider: quotient bits, divisor and dividend widths
  localparam int GPM_Q_W = GPM_AXIS_W - 1;
  localparam int GPM_R_W = GPM_AXIS_W;
  localparam int GPM_N_W = GPM_R_W + GPM_Q_W - 1;

  // Pipeline: prep stage, one stage per quotient bit, output stage
  localparam int GPM_STAGES = GPM_Q_W + 2;

  // Configuration port
  localparam int GPM_ADDR_W = 5;
  localparam int GPM_DATA_W = 32;

  localparam logic [GPM_AXIS_W-1:0] GPM_CENTER    = 8'd128;
  localparam logic [GPM_TRIG_W-1:0] GPM_TRIG_FULL = 8'd255;

  // Button bit positions
  localparam int GPM_BIT_UP    = 4;
  localparam int GPM_BIT_RIGHT = 5;
  localparam int GPM_BIT_DOWN  = 6;
  localparam int GPM_BIT_LEFT  = 7;
  localparam int GPM_BIT_L2    = 8;
  localparam int GPM_BIT_R2    = 9;

  localparam logic [GPM_BTN_W-1:0] GPM_DPAD_MASK = 16'h00F0;

  // Hat codes, clockwise from up
  localparam logic [GPM_HAT_W-1:0] GPM_HAT_N       = 4'd0;
  localparam logic [GPM_HAT_W-1:0] GPM_HAT_NE      = 4'd1;
  localparam logic [GPM_HAT_W-1:0] GPM_HAT_E       = 4'd2;
  localparam logic [GPM_HAT_W-1:0] GPM_HAT_SE      = 4'd3;
  localparam logic [GPM_HAT_W-1:0] GPM_HAT_S       = 4'd4;
  localparam logic [GPM_HAT_W-1:0] GPM_HAT_SW      = 4'd5;
  localparam logic [GPM_HAT_W-1:0] GPM_HAT_W_DIR   = 4'd6;
  localparam logic [GPM_HAT_W-1:0] GPM_HAT_NW      = 4'd7;
  localparam logic [GPM_HAT_W-1:0] GPM_HAT_NEUTRAL = 4'd8;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_HAT_ENABLE     = 3'd0,
    REG_LEFT_DZ        = 3'd1,
    REG_RIGHT_DZ       = 3'd2,
    REG_INV_LEFT_VERT  = 3'd3,
    REG_INV_RIGHT_VERT = 3'd4,
    REG_PRESSURE_TRIG  = 3'd5,
    REG_FULL_SCALE     = 3'd6,
    REG_STRIP_DPAD     = 3'd7
  } gpm_reg_t;

  // Non-axis fields that ride along the pipeline
  typedef struct packed {
    logic                  present;
    logic [GPM_BTN_W-1:0]  buttons;
    logic [GPM_HAT_W-1:0]  hat;
    logic [GPM_TRIG_W-1:0] left_trig;
    logic [GPM_TRIG_W-1:0] right_trig;
  } gpm_side_t;

  // D-pad to 8-way hat; opposing directions read as neutral
  function automatic logic [GPM_HAT_W-1:0] gpm_hat(input logic [GPM_BTN_W-1:0] b);
    logic up, rt, dn, lf;
    logic [GPM_HAT_W-1:0] h;
    up = b[GPM_BIT_UP];
    rt = b[GPM_BIT_RIGHT];
    dn = b[GPM_BIT_DOWN];
    lf = b[GPM_BIT_LEFT];
    if ((up && dn) || (lf && rt)) h = GPM_HAT_NEUTRAL;
    else if (up && rt)            h = GPM_HAT_NE;
    else if (rt && dn)            h = GPM_HAT_SE;
    else if (dn && lf)            h = GPM_HAT_SW;
    else if (lf && up)            h = GPM_HAT_NW;
    else if (up)                  h = GPM_HAT_N;
    else if (rt)                  h = GPM_HAT_E;
    else if (dn)                  h = GPM_HAT_S;
    else if (lf)                  h = GPM_HAT_W_DIR;
    else                          h = GPM_HAT_NEUTRAL;
    return h;
  endfunction

endpackage

>>> rtl/core/gpm_if.sv
// ----------------------------------------------------------------------------
// Gamepad report mapper channel interfaces
// Valid/ready channels for raw reports and mapped reports.
// ----------------------------------------------------------------------------

// Raw report channel
interface gpm_in_if;
  import gpm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  present;
  logic [GPM_BTN_W-1:0]  button_bits;
  logic [GPM_AXIS_W-1:0] left_horizontal;
  logic [GPM_AXIS_W-1:0] left_vertical;
  logic [GPM_AXIS_W-1:0] right_horizontal;
  logic [GPM_AXIS_W-1:0] right_vertical;
  logic [GPM_TRIG_W-1:0] left_trigger_pressure;
  logic [GPM_TRIG_W-1:0] right_trigger_pressure;

  modport source (
    output valid, present, button_bits, left_horizontal, left_vertical,
           right_horizontal, right_vertical, left_trigger_pressure,
           right_trigger_pressure,
    input  ready
  );

  modport sink (
    input  valid, present, button_bits, left_horizontal, left_vertical,
           right_horizontal, right_vertical, left_trigger_pressure,
           right_trigger_pressure,
    output ready
  );
endinterface

// Mapped report channel
interface gpm_out_if;
  import gpm_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         present_out;
  logic [GPM_BTN_W-1:0]         button_out;
  logic [GPM_HAT_W-1:0]         hat_code;
  logic signed [GPM_AXIS_W-1:0] left_x_out;
  logic signed [GPM_AXIS_W-1:0] left_y_out;
  logic signed [GPM_AXIS_W-1:0] right_x_out;
  logic signed [GPM_AXIS_W-1:0] right_y_out;
  logic [GPM_TRIG_W-1:0]        left_trigger_out;
  logic [GPM_TRIG_W-1:0]        right_trigger_out;

  modport source (
    output valid, present_out, button_out, hat_code, left_x_out, left_y_out,
           right_x_out, right_y_out, left_trigger_out, right_trigger_out,
    input  ready
  );

  modport sink (
    input  valid, present_out, button_out, hat_code, left_x_out, left_y_out,
           right_x_out, right_y_out, left_trigger_out, right_trigger_out,
    output ready
  );
endinterface

>>> rtl/core/gamepad_report_mapper.sv
// ----------------------------------------------------------------------------
// Gamepad report mapper
// Maps one raw controller report to one mapped report: buttons, hat, four
// rescaled stick axes and two trigger levels.
//
//   channel   direction  handshake      carries
//   in_rpt    in         valid/ready    raw report
//   out_rpt   out        valid/ready    mapped report
//   cfg_*     in         APB write/read eight control registers
//
// One report is taken every cycle while out_rpt.ready is high; the depth is set
// by the axis dividers, which resolve one quotient bit per stage over 7 stages.
// rst_n clears the stage valid bits and loads register defaults.
// A stage holds while its successor is full and stalled; empty stages fill,
// so in_rpt.ready stays high whenever out_rpt.ready is high.
// ----------------------------------------------------------------------------
`include "gamepad_report_mapper_assert.svh"

module gamepad_report_mapper (
  input  logic                              clk,
  input  logic                              rst_n,
  gpm_in_if.sink                            in_rpt,
  gpm_out_if.source                         out_rpt,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [gpm_pkg::GPM_ADDR_W-1:0]    cfg_paddr,
  input  logic [gpm_pkg::GPM_DATA_W-1:0]    cfg_pwdata,
  output logic [gpm_pkg::GPM_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import gpm_pkg::*;

  localparam int LAST = GPM_STAGES - 1;

  // Control registers
  logic                hat_enable_r;
  logic [GPM_DZ_W-1:0] left_dz_r;
  logic [GPM_DZ_W-1:0] right_dz_r;
  logic                inv_left_r;
  logic                inv_right_r;
  logic                pressure_r;
  logic                full_scale_r;
  logic                strip_dpad_r;

  gpm_reg_t cfg_idx;
  logic     cfg_wr;

  // Pipeline control
  logic [GPM_STAGES-1:0] v_r;
  logic [GPM_STAGES-1:0] v_nxt;
  logic [GPM_STAGES-1:0] v_up;
  logic [GPM_STAGES:0]   rdy;

  gpm_side_t side_nxt;
  gpm_side_t side_r [0:LAST];

  logic [GPM_BTN_W-1:0] btn;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_idx    = gpm_reg_t'(cfg_paddr[GPM_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hat_enable_r <= 1'b1;
      left_dz_r    <= '0;
      right_dz_r   <= '0;
      inv_left_r   <= 1'b0;
      inv_right_r  <= 1'b0;
      pressure_r   <= 1'b0;
      full_scale_r <= 1'b1;
      strip_dpad_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HAT_ENABLE:     hat_enable_r <= cfg_pwdata[0];
        REG_LEFT_DZ:        left_dz_r    <= cfg_pwdata[GPM_DZ_W-1:0];
        REG_RIGHT_DZ:       right_dz_r   <= cfg_pwdata[GPM_DZ_W-1:0];
        REG_INV_LEFT_VERT:  inv_left_r   <= cfg_pwdata[0];
        REG_INV_RIGHT_VERT: inv_right_r  <= cfg_pwdata[0];
        REG_PRESSURE_TRIG:  pressure_r   <= cfg_pwdata[0];
        REG_FULL_SCALE:     full_scale_r <= cfg_pwdata[0];
        REG_STRIP_DPAD:     strip_dpad_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_HAT_ENABLE:     cfg_prdata = GPM_DATA_W'(hat_enable_r);
      REG_LEFT_DZ:        cfg_prdata = GPM_DATA_W'(left_dz_r);
      REG_RIGHT_DZ:       cfg_prdata = GPM_DATA_W'(right_dz_r);
      REG_INV_LEFT_VERT:  cfg_prdata = GPM_DATA_W'(inv_left_r);
      REG_INV_RIGHT_VERT: cfg_prdata = GPM_DATA_W'(inv_right_r);
      REG_PRESSURE_TRIG:  cfg_prdata = GPM_DATA_W'(pressure_r);
      REG_FULL_SCALE:     cfg_prdata = GPM_DATA_W'(full_scale_r);
      REG_STRIP_DPAD:     cfg_prdata = GPM_DATA_W'(strip_dpad_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its successor moves
  // ---------------------------------------------------------------------------
  assign rdy[GPM_STAGES] = out_rpt.ready;
  for (genvar k = 0; k < GPM_STAGES; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign v_up = {v_r[LAST-1:0], in_rpt.valid};

  always_comb begin
    for (int k = 0; k < GPM_STAGES; k++) begin
      v_nxt[k] = rdy[k] ? v_up[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_rpt.ready = rdy[0];

  // ---------------------------------------------------------------------------
  // Buttons, hat and triggers, worked out on entry and carried along
  // ---------------------------------------------------------------------------
  assign btn = in_rpt.button_bits;

  always_comb begin
    side_nxt = '0;
    if (in_rpt.present) begin
      side_nxt.present = 1'b1;
      side_nxt.buttons = strip_dpad_r ? (btn & ~GPM_DPAD_MASK) : btn;
      side_nxt.hat     = hat_enable_r ? gpm_hat(btn) : GPM_HAT_NEUTRAL;

      if (pressure_r && (in_rpt.left_trigger_pressure != '0)) begin
        side_nxt.left_trig = in_rpt.left_trigger_pressure;
      end else if (btn[GPM_BIT_L2] && full_scale_r) begin
        side_nxt.left_trig = GPM_TRIG_FULL;
      end

      if (pressure_r && (in_rpt.right_trigger_pressure != '0)) begin
        side_nxt.right_trig = in_rpt.right_trigger_pressure;
      end else if (btn[GPM_BIT_R2] && full_scale_r) begin
        side_nxt.right_trig = GPM_TRIG_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side_r[0] <= side_nxt;
    end
  end

  for (genvar k = 1; k < GPM_STAGES; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stick axes
  // ---------------------------------------------------------------------------
  gpm_axis_lane u_left_x (
    .clk      (clk),
    .en       (rdy[LAST:0]),
    .present  (in_rpt.present),
    .raw      (in_rpt.left_horizontal),
    .dz       (left_dz_r),
    .inv      (1'b0),
    .axis_out (out_rpt.left_x_out)
  );

  gpm_axis_lane u_left_y (
    .clk      (clk),
    .en       (rdy[LAST:0]),
    .present  (in_rpt.present),
    .raw      (in_rpt.left_vertical),
    .dz       (left_dz_r),
    .inv      (inv_left_r),
    .axis_out (out_rpt.left_y_out)
  );

  gpm_axis_lane u_right_x (
    .clk      (clk),
    .en       (rdy[LAST:0]),
    .present  (in_rpt.present),
    .raw      (in_rpt.right_horizontal),
    .dz       (right_dz_r),
    .inv      (1'b0),
    .axis_out (out_rpt.right_x_out)
  );

  gpm_axis_lane u_right_y (
    .clk      (clk),
    .en       (rdy[LAST:0]),
    .present  (in_rpt.present),
    .raw      (in_rpt.right_vertical),
    .dz       (right_dz_r),
    .inv      (inv_right_r),
    .axis_out (out_rpt.right_y_out)
  );

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------
  assign out_rpt.valid             = v_r[LAST];
  assign out_rpt.present_out       = side_r[LAST].present;
  assign out_rpt.button_out        = side_r[LAST].buttons;
  assign out_rpt.hat_code          = side_r[LAST].hat;
  assign out_rpt.left_trigger_out  = side_r[LAST].left_trig;
  assign out_rpt.right_trigger_out = side_r[LAST].right_trig;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `GPM_ASSERT_SAME(a_no_block, out_rpt.ready, in_rpt.ready, "input blocked while sink ready")
  `GPM_ASSERT_NEXT(a_enter, in_rpt.valid && in_rpt.ready, v_r[0], "transfer lost at entry")
  `GPM_ASSERT_SAME(a_absent_zero, out_rpt.valid && !out_rpt.present_out, (out_rpt.hat_code == GPM_HAT_N) && (out_rpt.left_x_out == '0) && (out_rpt.right_y_out == '0), "absent report not zeroed")
  `GPM_ASSERT_SAME(a_axis_range, out_rpt.valid, (out_rpt.left_x_out != 8'h80) && (out_rpt.left_y_out != 8'h80) && (out_rpt.right_x_out != 8'h80) && (out_rpt.right_y_out != 8'h80), "axis out of range")

endmodule

>>> rtl/core/gpm_axis_lane.sv
// ----------------------------------------------------------------------------
// Gamepad axis lane
// Dead zone, rescale to -127..127 with rounding, and optional inversion of one
// stick axis; restoring divider with one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module gpm_axis_lane (
  input  logic                                  clk,
  input  logic [gpm_pkg::GPM_STAGES-1:0]        en,
  input  logic                                  present,
  input  logic [gpm_pkg::GPM_AXIS_W-1:0]        raw,
  input  logic [gpm_pkg::GPM_DZ_W-1:0]          dz,
  input  logic                                  inv,
  output logic signed [gpm_pkg::GPM_AXIS_W-1:0] axis_out
);
  import gpm_pkg::*;

  localparam int QW = GPM_Q_W;
  localparam int TW = GPM_N_W + 1;

  // Prep stage signals
  logic [GPM_AXIS_W-1:0] mag;
  logic [GPM_AXIS_W-1:0] dz_ext;
  logic [GPM_AXIS_W-1:0] excess;
  logic [GPM_R_W-1:0]    span;
  logic [GPM_N_W-1:0]    num_nxt;
  logic                  neg_nxt;

  // Stage registers: index 0 is prep, index k holds k quotient bits
  logic [GPM_N_W-1:0] rem_r [0:QW-1];
  logic [GPM_R_W-1:0] div_r [0:QW-1];
  logic [QW-1:0]      quo_r [0:QW];
  logic               neg_r [0:QW];

  logic signed [GPM_AXIS_W-1:0] axis_r;

  // Offset from center, dead zone, numerator (m - dz)*127 + r/2 over r = 128 - dz
  always_comb begin
    dz_ext = GPM_AXIS_W'(dz);
    if (raw[GPM_AXIS_W-1]) begin
      mag = GPM_AXIS_W'(raw[GPM_AXIS_W-2:0]);
    end else begin
      mag = GPM_CENTER - raw;
    end
    excess = mag - dz_ext;
    span   = GPM_CENTER - dz_ext;
    if (!present || (mag <= dz_ext)) begin
      num_nxt = '0;
      neg_nxt = 1'b0;
    end else begin
      // times 127 as a shift and subtract
      num_nxt = (GPM_N_W'(excess) << QW) - GPM_N_W'(excess)
              + GPM_N_W'(span >> 1);
      neg_nxt = !raw[GPM_AXIS_W-1] ^ inv;
    end
  end

  // Prep register
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= num_nxt;
      div_r[0] <= span;
      quo_r[0] <= '0;
      neg_r[0] <= neg_nxt;
    end
  end

  // One restoring division step per stage, MSB of the quotient first
  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [TW-1:0] shd;
    logic [TW-1:0] trial;
    logic [QW-1:0] quo_nxt;

    always_comb begin
      shd     = TW'(div_r[k-1]) << (QW - k);
      trial   = {1'b0, rem_r[k-1]} - shd;
      quo_nxt = quo_r[k-1];
      quo_nxt[QW-k] = !trial[TW-1];
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        quo_r[k] <= quo_nxt;
        neg_r[k] <= neg_r[k-1];
      end
    end

    if (k < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k] <= trial[TW-1] ? rem_r[k-1] : trial[GPM_N_W-1:0];
          div_r[k] <= div_r[k-1];
        end
      end
    end
  end

  // Output stage: apply sign; quotient never exceeds 127
  always_ff @(posedge clk) begin
    if (en[GPM_STAGES-1]) begin
      if (neg_r[QW]) begin
        axis_r <= -$signed({1'b0, quo_r[QW]});
      end else begin
        axis_r <= $signed({1'b0, quo_r[QW]});
      end
    end
  end

  assign axis_out = axis_r;

endmodule

>>> verif/gamepad_report_mapper_tb.sv
// ----------------------------------------------------------------------------
// Gamepad report mapper testbench
// Drives raw reports through the valid/ready input channel in random bursts,
// and rewrites the control registers over APB between drained phases. An
// in-bench mapping model predicts each mapped report. A checker compares
// every transfer on the output channel, field by field, against the oldest
// prediction, while the output side stalls on its own random pattern.
// ----------------------------------------------------------------------------
module gamepad_report_mapper_tb;
  import gpm_pkg::*;

  // Raw report as driven on the input channel
  typedef struct packed {
    logic                  present;
    logic [GPM_BTN_W-1:0]  buttons;
    logic [GPM_AXIS_W-1:0] lh;
    logic [GPM_AXIS_W-1:0] lv;
    logic [GPM_AXIS_W-1:0] rh;
    logic [GPM_AXIS_W-1:0] rv;
    logic [GPM_TRIG_W-1:0] lt_press;
    logic [GPM_TRIG_W-1:0] rt_press;
  } raw_rpt_t;

  // Mapped report as seen on the output channel
  typedef struct packed {
    logic                         present;
    logic [GPM_BTN_W-1:0]         buttons;
    logic [GPM_HAT_W-1:0]         hat;
    logic signed [GPM_AXIS_W-1:0] lx;
    logic signed [GPM_AXIS_W-1:0] ly;
    logic signed [GPM_AXIS_W-1:0] rx;
    logic signed [GPM_AXIS_W-1:0] ry;
    logic [GPM_TRIG_W-1:0]        lt;
    logic [GPM_TRIG_W-1:0]        rt;
  } mapped_rpt_t;

  // Control register settings
  typedef struct {
    logic                hat_enable;
    logic [GPM_DZ_W-1:0] left_dz;
    logic [GPM_DZ_W-1:0] right_dz;
    logic                inv_left;
    logic                inv_right;
    logic                pressure;
    logic                full_scale;
    logic                strip_dpad;
  } mapper_cfg_t;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [GPM_ADDR_W-1:0] cfg_paddr;
  logic [GPM_DATA_W-1:0] cfg_pwdata;
  logic [GPM_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  gpm_in_if  raw_ch ();
  gpm_out_if map_ch ();

  mapper_cfg_t cfg_shadow;
  mapped_rpt_t pending_reports[$];
  int          fail_count = 0;

  gamepad_report_mapper DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_rpt      (raw_ch),
    .out_rpt     (map_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model

  // D-pad nibble {left, down, right, up} to hat; opposing pairs are neutral
  function automatic logic [GPM_HAT_W-1:0] dpad_to_hat(logic [GPM_BTN_W-1:0] b);
    logic [3:0] d;
    d = {b[GPM_BIT_LEFT], b[GPM_BIT_DOWN], b[GPM_BIT_RIGHT], b[GPM_BIT_UP]};
    case (d)
      4'b0001: return GPM_HAT_N;
      4'b0011: return GPM_HAT_NE;
      4'b0010: return GPM_HAT_E;
      4'b0110: return GPM_HAT_SE;
      4'b0100: return GPM_HAT_S;
      4'b1100: return GPM_HAT_SW;
      4'b1000: return GPM_HAT_W_DIR;
      4'b1001: return GPM_HAT_NW;
      default: return GPM_HAT_NEUTRAL;
    endcase
  endfunction

  // Center, dead zone, rescale to +-127 with rounding, optional inversion
  function automatic logic signed [GPM_AXIS_W-1:0] stick_scale(
      logic [GPM_AXIS_W-1:0] raw, logic [GPM_DZ_W-1:0] dz, logic inv);
    int ctr, mag, span, val;
    ctr = int'(raw) - int'(GPM_CENTER);
    mag = (ctr < 0) ? -ctr : ctr;
    if (mag <= int'(dz)) return '0;
    span = 128 - int'(dz);
    val  = ((mag - int'(dz)) * 127 + span / 2) / span;
    if (val > 127) val = 127;
    if (ctr < 0) val = -val;
    if (inv) val = -val;
    return val[GPM_AXIS_W-1:0];
  endfunction

  function automatic logic [GPM_TRIG_W-1:0] trigger_level(logic pressed,
                                                          logic [GPM_TRIG_W-1:0] press);
    if (cfg_shadow.pressure && press != '0) return press;
    if (pressed && cfg_shadow.full_scale) return GPM_TRIG_FULL;
    return '0;
  endfunction

  function automatic mapped_rpt_t predict_report(raw_rpt_t r);
    mapped_rpt_t m;
    m = '0;
    if (!r.present) return m;
    m.present = 1'b1;
    m.buttons = cfg_shadow.strip_dpad ? (r.buttons & ~GPM_DPAD_MASK) : r.buttons;
    m.hat     = cfg_shadow.hat_enable ? dpad_to_hat(r.buttons) : GPM_HAT_NEUTRAL;
    m.lx      = stick_scale(r.lh, cfg_shadow.left_dz, 1'b0);
    m.ly      = stick_scale(r.lv, cfg_shadow.left_dz, cfg_shadow.inv_left);
    m.rx      = stick_scale(r.rh, cfg_shadow.right_dz, 1'b0);
    m.ry      = stick_scale(r.rv, cfg_shadow.right_dz, cfg_shadow.inv_right);
    m.lt      = trigger_level(r.buttons[GPM_BIT_L2], r.lt_press);
    m.rt      = trigger_level(r.buttons[GPM_BIT_R2], r.rt_press);
    return m;
  endfunction

  // ---------------------------------------------------------------- checker

  task automatic cmp_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Each output transfer against the oldest prediction
  always @(posedge clk) begin
    mapped_rpt_t e;
    if (rst_n && map_ch.valid && map_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("mapped report transfer with no prediction pending");
        fail_count++;
      end else begin
        e = pending_reports.pop_front();
        cmp_field("present_out", 64'(e.present), 64'(map_ch.present_out));
        cmp_field("button_out", 64'(e.buttons), 64'(map_ch.button_out));
        cmp_field("hat_code", 64'(e.hat), 64'(map_ch.hat_code));
        cmp_field("left_x_out", 64'(e.lx), 64'(map_ch.left_x_out));
        cmp_field("left_y_out", 64'(e.ly), 64'(map_ch.left_y_out));
        cmp_field("right_x_out", 64'(e.rx), 64'(map_ch.right_x_out));
        cmp_field("right_y_out", 64'(e.ry), 64'(map_ch.right_y_out));
        cmp_field("left_trigger_out", 64'(e.lt), 64'(map_ch.left_trigger_out));
        cmp_field("right_trigger_out", 64'(e.rt), 64'(map_ch.right_trigger_out));
      end
    end
  end

  // Output backpressure: ready runs of random length, short stalls between
  initial begin
    int hi_len, lo_len;
    map_ch.ready = 1'b0;
    forever begin
      hi_len = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      lo_len = $urandom_range(0, 5);
      repeat (hi_len) begin
        @(negedge clk);
        map_ch.ready <= 1'b1;
      end
      repeat (lo_len) begin
        @(negedge clk);
        map_ch.ready <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // One raw report; valid stays high after the transfer
  task automatic send_report(raw_rpt_t r);
    @(negedge clk);
    raw_ch.valid                  <= 1'b1;
    raw_ch.present                <= r.present;
    raw_ch.button_bits            <= r.buttons;
    raw_ch.left_horizontal        <= r.lh;
    raw_ch.left_vertical          <= r.lv;
    raw_ch.right_horizontal       <= r.rh;
    raw_ch.right_vertical         <= r.rv;
    raw_ch.left_trigger_pressure  <= r.lt_press;
    raw_ch.right_trigger_pressure <= r.rt_press;
    @(posedge clk);
    while (!raw_ch.ready) @(posedge clk);
    pending_reports.push_back(predict_report(r));
  endtask

  task automatic idle_input(int cycles);
    @(negedge clk);
    raw_ch.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stop sending and wait for every predicted report to come out
  task automatic drain_reports();
    @(negedge clk);
    raw_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  // APB write with junk above the register width; the block must mask it
  task automatic cfg_write(gpm_reg_t idx, int unsigned value);
    int unsigned           w;
    logic [GPM_DATA_W-1:0] data;
    w    = (idx == REG_LEFT_DZ || idx == REG_RIGHT_DZ) ? GPM_DZ_W : 1;
    data = (value & ((32'd1 << w) - 1)) | ($urandom() << w);
    case (idx)
      REG_HAT_ENABLE:     cfg_shadow.hat_enable = data[0];
      REG_LEFT_DZ:        cfg_shadow.left_dz    = data[GPM_DZ_W-1:0];
      REG_RIGHT_DZ:       cfg_shadow.right_dz   = data[GPM_DZ_W-1:0];
      REG_INV_LEFT_VERT:  cfg_shadow.inv_left   = data[0];
      REG_INV_RIGHT_VERT: cfg_shadow.inv_right  = data[0];
      REG_PRESSURE_TRIG:  cfg_shadow.pressure   = data[0];
      REG_FULL_SCALE:     cfg_shadow.full_scale = data[0];
      REG_STRIP_DPAD:     cfg_shadow.strip_dpad = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic cfg_apply(mapper_cfg_t c);
    drain_reports();
    cfg_write(REG_HAT_ENABLE, 32'(c.hat_enable));
    cfg_write(REG_LEFT_DZ, 32'(c.left_dz));
    cfg_write(REG_RIGHT_DZ, 32'(c.right_dz));
    cfg_write(REG_INV_LEFT_VERT, 32'(c.inv_left));
    cfg_write(REG_INV_RIGHT_VERT, 32'(c.inv_right));
    cfg_write(REG_PRESSURE_TRIG, 32'(c.pressure));
    cfg_write(REG_FULL_SCALE, 32'(c.full_scale));
    cfg_write(REG_STRIP_DPAD, 32'(c.strip_dpad));
  endtask

  // ---------------------------------------------------------------- stimulus

  // Axis values lean toward the ends and the dead zone edges
  function automatic logic [GPM_AXIS_W-1:0] pick_axis(logic [GPM_DZ_W-1:0] dz);
    int off, v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 6))
          0: v = 0;
          1: v = 1;
          2: v = 127;
          3: v = 128;
          4: v = 129;
          5: v = 254;
          default: v = 255;
        endcase
      end
      1: begin
        off = int'(dz) + $urandom_range(0, 1);
        v   = $urandom_range(0, 1) ? 128 + off : 128 - off;
        if (v > 255) v = 255;
        if (v < 0) v = 0;
      end
      default: v = $urandom_range(0, 255);
    endcase
    return v[GPM_AXIS_W-1:0];
  endfunction

  function automatic raw_rpt_t random_report();
    raw_rpt_t r;
    r.present  = ($urandom_range(0, 7) != 0);
    r.buttons  = GPM_BTN_W'($urandom_range(0, 16'hFFFF));
    r.lh       = pick_axis(cfg_shadow.left_dz);
    r.lv       = pick_axis(cfg_shadow.left_dz);
    r.rh       = pick_axis(cfg_shadow.right_dz);
    r.rv       = pick_axis(cfg_shadow.right_dz);
    r.lt_press = ($urandom_range(0, 3) == 0) ? '0 : GPM_TRIG_W'($urandom_range(0, 255));
    r.rt_press = ($urandom_range(0, 3) == 0) ? '0 : GPM_TRIG_W'($urandom_range(0, 255));
    return r;
  endfunction

  // Random reports in bursts with random gaps
  task automatic run_traffic(int count);
    int sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 16);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_report(random_report());
        sent++;
      end
      gap = $urandom_range(0, 4);
      if (gap > 0) idle_input(gap);
    end
  endtask

  // Every d-pad combination, reset settings
  task automatic test_dpad_hat();
    raw_rpt_t r;
    for (int d = 0; d < 16; d++) begin
      r = random_report();
      r.present = 1'b1;
      r.buttons[GPM_BIT_LEFT:GPM_BIT_UP] = d[3:0];
      send_report(r);
    end
  endtask

  // Full deflection, center and one step off center; triggers at the ends
  task automatic test_axis_extremes();
    raw_rpt_t r;
    logic [GPM_AXIS_W-1:0] vals[6];
    vals = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd129, 8'd1};
    for (int i = 0; i < 6; i++) begin
      r          = '0;
      r.present  = 1'b1;
      r.buttons  = (i % 2) ? 16'hFFFF : 16'h0300;
      r.lh       = vals[i];
      r.lv       = vals[(i + 1) % 6];
      r.rh       = vals[(i + 2) % 6];
      r.rv       = vals[(i + 3) % 6];
      r.lt_press = (i % 3 == 0) ? 8'd0 : 8'd255;
      r.rt_press = (i % 3 == 1) ? 8'd0 : 8'd255;
      send_report(r);
    end
  endtask

  // Disconnected reports must map to all zeros whatever they carry
  task automatic test_disconnected();
    raw_rpt_t r;
    r = '1;
    r.present = 1'b0;
    send_report(r);
    r = random_report();
    r.present = 1'b0;
    send_report(r);
  endtask

  // Fixed corner settings, then random ones
  task automatic test_settings_sweep();
    mapper_cfg_t c;
    c = '{1'b0, 7'd127, 7'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    cfg_apply(c);
    run_traffic(70);
    c = '{1'b1, 7'd0, 7'd127, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    cfg_apply(c);
    run_traffic(70);
    c = '{1'b1, 7'd127, 7'd127, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
    cfg_apply(c);
    run_traffic(70);
    c = '{1'b0, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    cfg_apply(c);
    run_traffic(70);
    repeat (4) begin
      c.hat_enable = 1'($urandom_range(0, 1));
      c.left_dz    = GPM_DZ_W'($urandom_range(0, 127));
      c.right_dz   = GPM_DZ_W'($urandom_range(0, 127));
      c.inv_left   = 1'($urandom_range(0, 1));
      c.inv_right  = 1'($urandom_range(0, 1));
      c.pressure   = 1'($urandom_range(0, 1));
      c.full_scale = 1'($urandom_range(0, 1));
      c.strip_dpad = 1'($urandom_range(0, 1));
      cfg_apply(c);
      run_traffic(80);
    end
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    rst_n                         = 1'b0;
    cfg_psel                      = 1'b0;
    cfg_penable                   = 1'b0;
    cfg_pwrite                    = 1'b0;
    cfg_paddr                     = '0;
    cfg_pwdata                    = '0;
    raw_ch.valid                  = 1'b0;
    raw_ch.present                = 1'b0;
    raw_ch.button_bits            = '0;
    raw_ch.left_horizontal        = '0;
    raw_ch.left_vertical          = '0;
    raw_ch.right_horizontal       = '0;
    raw_ch.right_vertical         = '0;
    raw_ch.left_trigger_pressure  = '0;
    raw_ch.right_trigger_pressure = '0;
    cfg_shadow = '{1'b1, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_dpad_hat();
    test_axis_extremes();
    test_disconnected();
    test_settings_sweep();

    drain_reports();
    repeat (2 * GPM_STAGES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
